// ----- hw/rtl/hfb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfb_pkg
// Types, constants and helper functions of the hierarchical free bitmap.
// ----------------------------------------------------------------------------
package hfb_pkg;

    localparam int unsigned WORD_W    = 32;
    localparam int unsigned SHIFT     = 5;
    localparam int unsigned MID_WORDS = 32;
    localparam int unsigned BOT_WORDS = 1024;
    localparam int unsigned BOT_AW    = 10;
    localparam int unsigned MAX_BINS  = 32768;
    localparam int unsigned EFF_MAX   = (MAX_BINS < 32768) ? MAX_BINS : 32768;
    localparam int unsigned GUARD_MAX = 256;

    localparam logic [WORD_W-1:0] ONES = {WORD_W{1'b1}};

    typedef logic [15:0] t_count;
    typedef logic [1:0]  t_lvl;
    typedef logic [16:0] t_widx;

    typedef enum logic [2:0] {
        OP_INIT_FREE  = 3'd0,
        OP_INIT_USED  = 3'd1,
        OP_SET_USED   = 3'd2,
        OP_SET_FREE   = 3'd3,
        OP_GET        = 3'd4,
        OP_FIND       = 3'd5,
        OP_FIND_SET   = 3'd6,
        OP_NEXT_ABOVE = 3'd7
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_SWEEP,
        ST_RD,
        ST_EV,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        PH_MARK,
        PH_FIND_LOW,
        PH_FIND_ABOVE,
        PH_GET
    } t_phase;

    localparam t_lvl LVL_TOP = 2'd0;
    localparam t_lvl LVL_TWO = 2'd1;
    localparam t_lvl LVL_ALL = 2'd2;

    function automatic t_count eff_count(input t_count bc);
        t_count c;
        c = bc;
        if (c == 16'd0) c = 16'd1;
        if (32'(c) > EFF_MAX) c = 16'(EFF_MAX);
        return c;
    endfunction

    function automatic t_lvl level_count(input t_count c);
        t_lvl l;
        if (c <= 16'd32) l = LVL_TOP;
        else if (c <= 16'd1024) l = LVL_TWO;
        else l = LVL_ALL;
        return l;
    endfunction

    function automatic logic [WORD_W-1:0] init_word(input t_count len,
                                                    input logic [BOT_AW-1:0] i);
        logic [10:0]       full;
        logic [4:0]        rem;
        logic [WORD_W-1:0] w;
        full = len[15:5];
        rem  = len[4:0];
        if ({1'b0, i} < full) w = '0;
        else if (({1'b0, i} == full) && (rem != 5'd0)) w = ONES << rem;
        else w = ONES;
        return w;
    endfunction

endpackage

// ----- hw/rtl/hfb_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfb_in_if
// Request channel: opcode and bin index.
// ----------------------------------------------------------------------------
interface hfb_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  opcode;
    logic [14:0] bin_index;
    modport source (output valid, output opcode, output bin_index, input ready);
    modport sink   (input valid, input opcode, input bin_index, output ready);
endinterface

// ----- hw/rtl/hfb_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfb_out_if
// Result channel: search outcome and read bit.
// ----------------------------------------------------------------------------
interface hfb_out_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [14:0] found_index;
    logic        bit_value;
    modport source (output valid, output found, output found_index, output bit_value,
                    input ready);
    modport sink   (input valid, input found, input found_index, input bit_value,
                    output ready);
endinterface

// ----- hw/rtl/hfb_cfg_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfb_cfg_if
// Configuration write channel for the bin count.
// ----------------------------------------------------------------------------
interface hfb_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/hfb_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfb_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module hfb_ram #(
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;

endmodule

// ----- hw/rtl/hfb_scan.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfb_scan
// Lowest set bit of a word; index 31 when the word is empty.
// ----------------------------------------------------------------------------
module hfb_scan (
    input  logic [hfb_pkg::WORD_W-1:0] i_word,
    output logic                       o_nz,
    output logic [hfb_pkg::SHIFT-1:0]  o_pos
);

    always_comb begin
        o_pos = 5'd31;
        for (int i = hfb_pkg::WORD_W - 1; i >= 0; i--) begin
            if (i_word[i]) o_pos = 5'(i);
        end
    end

    assign o_nz = (i_word != '0);

endmodule

// ----- hw/rtl/hierarchical_free_bitmap.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hierarchical_free_bitmap
// Three-level 32-way free bitmap with init, set, clear, get and free-bin searches.
// ----------------------------------------------------------------------------
// Sequencing: requests walk the levels a word at a time through read and evaluate states
// (find-and-claim then marks the bin used, next-above stops at the step guard, init
// sweeps every bottom-level word) using the shared scanner; results wait while output stalls.
// Throughput: one request at a time; ready is high only while idle.
// Reset: synchronous; a sweep pass writes every bottom-level word to all used,
// during which no request is accepted. Configuration is accepted at any time.
module hierarchical_free_bitmap (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hfb_in_if.sink     i_in,
    hfb_out_if.source  o_out,
    hfb_cfg_if.sink    i_cfg
);

    hfb_pkg::t_state r_state, n_state;
    hfb_pkg::t_phase r_phase, n_phase;
    hfb_pkg::t_op    r_op, n_op;
    hfb_pkg::t_count r_bin_count;
    hfb_pkg::t_lvl   r_d, n_d;
    hfb_pkg::t_widx  r_wi, n_wi;
    logic [4:0]      r_pos, n_pos;
    logic [14:0]     r_idx, n_idx;
    logic            r_used, n_used;
    logic [8:0]      r_guard, n_guard;
    logic            r_found, n_found;
    logic [14:0]     r_fidx, n_fidx;
    logic            r_bitv, n_bitv;
    logic [9:0]      r_fill, n_fill;
    logic            r_sweep_op, n_sweep_op;
    logic            r_sweep_free, n_sweep_free;
    logic            r_out_valid;
    logic            r_out_found;
    logic [14:0]     r_out_fidx;
    logic            r_out_bitv;
    logic [31:0]     r_top, n_top;
    logic [31:0]     r_mid [hfb_pkg::MID_WORDS];

    hfb_pkg::t_count c;
    hfb_pkg::t_lvl   lvl;
    hfb_pkg::t_count len_m;
    hfb_pkg::t_count len_t;
    hfb_pkg::t_count len0;
    logic [31:0]     top_init;
    logic [31:0]     word;
    logic [31:0]     scan_w;
    logic            scan_nz;
    logic [4:0]      scan_pos;
    hfb_pkg::t_widx  wi_sh;
    hfb_pkg::t_widx  nwi;
    logic            at_bottom;
    logic            nwi_oob;
    logic [31:0]     mark_bit;
    logic [31:0]     mark_nw;
    logic            mark_cont;
    logic [5:0]      ib_up;
    logic            in_acc;
    logic            out_load;
    hfb_pkg::t_op    in_op;
    logic            ram_we;
    logic [9:0]      ram_waddr;
    logic [31:0]     ram_wdata;
    logic            ram_re;
    logic [9:0]      ram_raddr;
    logic [31:0]     ram_q;
    logic            mid_we;
    logic            mid_init;

    assign c      = hfb_pkg::eff_count(r_bin_count);
    assign lvl    = hfb_pkg::level_count(c);
    assign len_m  = 16'((17'(c) + 17'd31) >> hfb_pkg::SHIFT);
    assign len_t  = 16'((17'(len_m) + 17'd31) >> hfb_pkg::SHIFT);
    assign len0   = (lvl == hfb_pkg::LVL_TOP) ? c :
                    (lvl == hfb_pkg::LVL_TWO) ? len_m : len_t;
    assign top_init = (len0 >= 16'd32) ? 32'd0 : (hfb_pkg::ONES << len0[4:0]);

    assign in_acc   = i_in.valid && i_in.ready;
    assign in_op    = hfb_pkg::t_op'(i_in.opcode);
    assign out_load = (r_state == hfb_pkg::ST_DONE) && (!r_out_valid || o_out.ready);

    always_comb begin
        if (r_d == hfb_pkg::LVL_TOP) begin
            word = (r_wi == '0) ? r_top : hfb_pkg::ONES;
        end else if (r_d == lvl) begin
            word = (r_wi < 17'(hfb_pkg::BOT_WORDS)) ? ram_q : hfb_pkg::ONES;
        end else begin
            word = (r_wi < 17'(hfb_pkg::MID_WORDS)) ? r_mid[r_wi[4:0]] : hfb_pkg::ONES;
        end
    end

    assign scan_w = (r_phase == hfb_pkg::PH_FIND_ABOVE) ?
                    (~word & (hfb_pkg::ONES << r_pos)) : ~word;

    hfb_scan u_scan (
        .i_word (scan_w),
        .o_nz   (scan_nz),
        .o_pos  (scan_pos)
    );

    assign wi_sh     = r_wi >> hfb_pkg::SHIFT;
    assign nwi       = (r_wi << hfb_pkg::SHIFT) + 17'(scan_pos);
    assign at_bottom = (r_d == lvl);
    assign nwi_oob   = (nwi >= 17'(c));
    assign mark_bit  = 32'd1 << r_pos;
    assign mark_nw   = r_used ? (word | mark_bit) : (word & ~mark_bit);
    assign mark_cont = r_used ? (mark_nw == hfb_pkg::ONES) : (word == hfb_pkg::ONES);
    assign ib_up     = 6'(r_wi[4:0]) + 6'd1;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            hfb_pkg::ST_IDLE: begin
                if (in_acc) begin
                    case (in_op)
                        hfb_pkg::OP_INIT_FREE,
                        hfb_pkg::OP_INIT_USED:  n_state = hfb_pkg::ST_INIT;
                        hfb_pkg::OP_SET_USED,
                        hfb_pkg::OP_SET_FREE:   n_state = ({1'b0, i_in.bin_index} < c) ?
                                                          hfb_pkg::ST_RD : hfb_pkg::ST_DONE;
                        hfb_pkg::OP_GET:        n_state = (({1'b0, i_in.bin_index} < c) &&
                                                           (lvl != hfb_pkg::LVL_TOP)) ?
                                                          hfb_pkg::ST_RD : hfb_pkg::ST_DONE;
                        hfb_pkg::OP_FIND,
                        hfb_pkg::OP_FIND_SET:   n_state = hfb_pkg::ST_RD;
                        hfb_pkg::OP_NEXT_ABOVE: n_state = ((16'(i_in.bin_index) + 16'd1) < c) ?
                                                          hfb_pkg::ST_RD : hfb_pkg::ST_DONE;
                        default:                n_state = hfb_pkg::ST_DONE;
                    endcase
                end
            end
            hfb_pkg::ST_INIT: n_state = hfb_pkg::ST_SWEEP;
            hfb_pkg::ST_SWEEP: begin
                if (r_fill == 10'(hfb_pkg::BOT_WORDS - 1)) begin
                    n_state = r_sweep_op ? hfb_pkg::ST_DONE : hfb_pkg::ST_IDLE;
                end
            end
            hfb_pkg::ST_RD: begin
                if ((r_phase == hfb_pkg::PH_MARK) && (r_d == hfb_pkg::LVL_TOP)) begin
                    n_state = hfb_pkg::ST_DONE;
                end else if ((r_phase == hfb_pkg::PH_FIND_ABOVE) &&
                             (r_guard >= 9'(hfb_pkg::GUARD_MAX))) begin
                    n_state = hfb_pkg::ST_DONE;
                end else begin
                    n_state = hfb_pkg::ST_EV;
                end
            end
            hfb_pkg::ST_EV: begin
                case (r_phase)
                    hfb_pkg::PH_MARK: begin
                        n_state = mark_cont ? hfb_pkg::ST_RD : hfb_pkg::ST_DONE;
                    end
                    hfb_pkg::PH_FIND_LOW: begin
                        if (word == hfb_pkg::ONES) n_state = hfb_pkg::ST_DONE;
                        else if (at_bottom) n_state = (!nwi_oob &&
                                                       (r_op == hfb_pkg::OP_FIND_SET)) ?
                                                      hfb_pkg::ST_RD : hfb_pkg::ST_DONE;
                        else n_state = hfb_pkg::ST_RD;
                    end
                    hfb_pkg::PH_FIND_ABOVE: begin
                        if (scan_nz) n_state = at_bottom ? hfb_pkg::ST_DONE : hfb_pkg::ST_RD;
                        else n_state = (r_d == hfb_pkg::LVL_TOP) ?
                                       hfb_pkg::ST_DONE : hfb_pkg::ST_RD;
                    end
                    default: n_state = hfb_pkg::ST_DONE;
                endcase
            end
            hfb_pkg::ST_DONE: begin
                if (out_load) n_state = hfb_pkg::ST_IDLE;
            end
            default: n_state = hfb_pkg::ST_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_phase      = r_phase;
        n_op         = r_op;
        n_d          = r_d;
        n_wi         = r_wi;
        n_pos        = r_pos;
        n_idx        = r_idx;
        n_used       = r_used;
        n_guard      = r_guard;
        n_found      = r_found;
        n_fidx       = r_fidx;
        n_bitv       = r_bitv;
        n_fill       = r_fill;
        n_sweep_op   = r_sweep_op;
        n_sweep_free = r_sweep_free;
        n_top        = r_top;
        ram_we       = 1'b0;
        ram_waddr    = r_wi[9:0];
        ram_wdata    = mark_nw;
        ram_re       = 1'b0;
        ram_raddr    = (r_phase == hfb_pkg::PH_MARK) ? wi_sh[9:0] : r_wi[9:0];
        mid_we       = 1'b0;
        mid_init     = 1'b0;
        case (r_state)
            hfb_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_op    = in_op;
                    n_idx   = i_in.bin_index;
                    n_found = 1'b0;
                    n_fidx  = '0;
                    n_bitv  = 1'b0;
                    n_guard = '0;
                    case (in_op)
                        hfb_pkg::OP_INIT_FREE,
                        hfb_pkg::OP_INIT_USED: begin
                            n_sweep_free = (in_op == hfb_pkg::OP_INIT_FREE);
                            n_sweep_op   = 1'b1;
                        end
                        hfb_pkg::OP_SET_USED,
                        hfb_pkg::OP_SET_FREE: begin
                            n_phase = hfb_pkg::PH_MARK;
                            n_d     = lvl;
                            n_wi    = 17'(i_in.bin_index);
                            n_used  = (in_op == hfb_pkg::OP_SET_USED);
                        end
                        hfb_pkg::OP_GET: begin
                            n_phase = hfb_pkg::PH_GET;
                            n_d     = lvl;
                            n_wi    = 17'(i_in.bin_index >> hfb_pkg::SHIFT);
                            if ({1'b0, i_in.bin_index} >= c) n_bitv = 1'b1;
                            else if (lvl == hfb_pkg::LVL_TOP) n_bitv = r_top[i_in.bin_index[4:0]];
                        end
                        hfb_pkg::OP_FIND,
                        hfb_pkg::OP_FIND_SET: begin
                            n_phase = hfb_pkg::PH_FIND_LOW;
                            n_d     = hfb_pkg::LVL_TOP;
                            n_wi    = '0;
                        end
                        hfb_pkg::OP_NEXT_ABOVE: begin
                            n_phase = hfb_pkg::PH_FIND_ABOVE;
                            n_d     = lvl;
                            n_wi    = 17'(i_in.bin_index >> hfb_pkg::SHIFT);
                            if (i_in.bin_index[4:0] == 5'd31) begin
                                n_wi  = 17'(i_in.bin_index >> hfb_pkg::SHIFT) + 17'd1;
                                n_pos = 5'd0;
                            end else begin
                                n_pos = i_in.bin_index[4:0] + 5'd1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            hfb_pkg::ST_INIT: begin
                n_top    = r_sweep_free ? top_init : hfb_pkg::ONES;
                mid_init = 1'b1;
                n_fill   = '0;
            end
            hfb_pkg::ST_SWEEP: begin
                ram_we    = 1'b1;
                ram_waddr = r_fill;
                ram_wdata = (r_sweep_free && (lvl != hfb_pkg::LVL_TOP)) ?
                            hfb_pkg::init_word(c, r_fill) : hfb_pkg::ONES;
                n_fill    = r_fill + 10'd1;
            end
            hfb_pkg::ST_RD: begin
                if (r_phase == hfb_pkg::PH_MARK) begin
                    if (r_d == hfb_pkg::LVL_TOP) begin
                        n_top = r_used ? (r_top | (32'd1 << r_wi[4:0])) :
                                         (r_top & ~(32'd1 << r_wi[4:0]));
                    end else begin
                        ram_re = 1'b1;
                        n_pos  = r_wi[4:0];
                        n_wi   = wi_sh;
                    end
                end else begin
                    ram_re = 1'b1;
                end
            end
            hfb_pkg::ST_EV: begin
                case (r_phase)
                    hfb_pkg::PH_MARK: begin
                        if (at_bottom) ram_we = 1'b1;
                        else mid_we = 1'b1;
                        if (mark_cont) n_d = r_d - 2'd1;
                    end
                    hfb_pkg::PH_FIND_LOW: begin
                        if (word != hfb_pkg::ONES) begin
                            n_wi = nwi;
                            if (at_bottom) begin
                                if (!nwi_oob) begin
                                    n_found = 1'b1;
                                    n_fidx  = nwi[14:0];
                                    n_phase = hfb_pkg::PH_MARK;
                                    n_used  = 1'b1;
                                end
                            end else begin
                                n_d = r_d + 2'd1;
                            end
                        end
                    end
                    hfb_pkg::PH_FIND_ABOVE: begin
                        n_guard = r_guard + 9'd1;
                        if (scan_nz) begin
                            if (at_bottom) begin
                                if (!nwi_oob) begin
                                    n_found = 1'b1;
                                    n_fidx  = nwi[14:0];
                                end
                            end else begin
                                n_d   = r_d + 2'd1;
                                n_wi  = nwi;
                                n_pos = 5'd0;
                            end
                        end else if (r_d != hfb_pkg::LVL_TOP) begin
                            n_d = r_d - 2'd1;
                            if (ib_up == 6'd32) begin
                                n_wi  = wi_sh + 17'd1;
                                n_pos = 5'd0;
                            end else begin
                                n_wi  = wi_sh;
                                n_pos = ib_up[4:0];
                            end
                        end
                    end
                    hfb_pkg::PH_GET: begin
                        n_bitv = word[r_idx[4:0]];
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    hfb_ram #(
        .DEPTH (hfb_pkg::BOT_WORDS),
        .WIDTH (hfb_pkg::WORD_W)
    ) u_bot (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= hfb_pkg::ST_SWEEP;
            r_fill       <= '0;
            r_sweep_op   <= 1'b0;
            r_sweep_free <= 1'b0;
            r_out_valid  <= 1'b0;
            r_bin_count  <= 16'd32768;
            r_top        <= hfb_pkg::ONES;
            for (int i = 0; i < hfb_pkg::MID_WORDS; i++) r_mid[i] <= hfb_pkg::ONES;
        end else begin
            r_state      <= n_state;
            r_fill       <= n_fill;
            r_sweep_op   <= n_sweep_op;
            r_sweep_free <= n_sweep_free;
            r_top        <= n_top;
            if (i_cfg.valid && i_cfg.ready) r_bin_count <= i_cfg.data;
            if (out_load) r_out_valid <= 1'b1;
            else if (o_out.ready) r_out_valid <= 1'b0;
            if (mid_init) begin
                for (int i = 0; i < hfb_pkg::MID_WORDS; i++) begin
                    r_mid[i] <= (r_sweep_free && (lvl == hfb_pkg::LVL_ALL)) ?
                                hfb_pkg::init_word(len_m, 10'(i)) : hfb_pkg::ONES;
                end
            end else if (mid_we) begin
                r_mid[r_wi[4:0]] <= mark_nw;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_phase <= n_phase;
        r_op    <= n_op;
        r_d     <= n_d;
        r_wi    <= n_wi;
        r_pos   <= n_pos;
        r_idx   <= n_idx;
        r_used  <= n_used;
        r_guard <= n_guard;
        r_found <= n_found;
        r_fidx  <= n_fidx;
        r_bitv  <= n_bitv;
        if (out_load) begin
            r_out_found <= r_found;
            r_out_fidx  <= r_fidx;
            r_out_bitv  <= r_bitv;
        end
    end

    assign i_in.ready        = (r_state == hfb_pkg::ST_IDLE);
    assign i_cfg.ready       = 1'b1;
    assign o_out.valid       = r_out_valid;
    assign o_out.found       = r_out_found;
    assign o_out.found_index = r_out_fidx;
    assign o_out.bit_value   = r_out_bitv;

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !i_in.ready)
        else $error("request taken while busy");
    a_no_req_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == hfb_pkg::ST_SWEEP) |-> !i_in.ready)
        else $error("request taken during sweep");
    a_found_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == hfb_pkg::ST_DONE && r_found) |-> ({1'b0, r_fidx} < c))
        else $error("found index beyond bin count");
    a_guard_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == hfb_pkg::ST_EV) |-> (r_guard < 9'(hfb_pkg::GUARD_MAX)))
        else $error("search step count overrun");
`endif

endmodule
